@@ rtl/core/sle_pkg.sv @@
// Shared constants, codes and control/status types for the serial line editor.
package sle_pkg;

	localparam int LINE_MAX_DEF = 32;
	localparam int LIMIT_W      = 6;
	localparam int BYTE_W       = 8;
	localparam int KIND_W       = 2;
	localparam int LEN_W        = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd32;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

	// console characters
	localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
	localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

	// output word source select
	localparam logic [2:0] SRC_RX   = 3'd0;
	localparam logic [2:0] SRC_BS   = 3'd1;
	localparam logic [2:0] SRC_SP   = 3'd2;
	localparam logic [2:0] SRC_CR   = 3'd3;
	localparam logic [2:0] SRC_LF   = 3'd4;
	localparam logic [2:0] SRC_LINE = 3'd5;
	localparam logic [2:0] SRC_END  = 3'd6;

	typedef struct packed {
		logic       store_wr;
		logic       fill_inc;
		logic       fill_dec;
		logic       fill_clr;
		logic       abort_ld;
		logic       walk_clr;
		logic       walk_inc;
		logic       emit;
		logic       last;
		logic [2:0] src;
	} sle_cmd_t;

	typedef struct packed {
		logic printable;
		logic erase;
		logic cr;
		logic etx;
		logic can_store;
		logic fill_nz;
		logic walk_last;
	} sle_stat_t;

endpackage

@@ rtl/core/sle_ctrl.sv @@
// Sequencer for the line editor: decodes accepted bytes and steps the emit sequences.
module sle_ctrl import sle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  sle_stat_t stat,
	output sle_cmd_t  cmd,
	output logic      busy
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BS1  = 3'd1;
	localparam logic [2:0] ST_BS2  = 3'd2;
	localparam logic [2:0] ST_LF   = 3'd3;
	localparam logic [2:0] ST_LINE = 3'd4;
	localparam logic [2:0] ST_END  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.src = SRC_RX;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (stat.printable) begin
						if (stat.can_store) begin
							cmd.store_wr = 1'b1;
							cmd.fill_inc = 1'b1;
							cmd.emit     = 1'b1;
							cmd.last     = 1'b1;
							cmd.src      = SRC_RX;
						end
					end else if (stat.erase) begin
						if (stat.fill_nz) begin
							cmd.fill_dec = 1'b1;
							cmd.emit     = 1'b1;
							cmd.src      = SRC_BS;
							state_d      = ST_BS1;
						end
					end else if (stat.cr || stat.etx) begin
						// ctrl-C empties the line now so the marker reports zero
						cmd.fill_clr = stat.etx;
						cmd.abort_ld = 1'b1;
						cmd.emit     = 1'b1;
						cmd.src      = SRC_CR;
						state_d      = ST_LF;
					end
				end
			end
			ST_BS1: begin
				cmd.emit = 1'b1;
				cmd.src  = SRC_SP;
				state_d  = ST_BS2;
			end
			ST_BS2: begin
				cmd.emit = 1'b1;
				cmd.last = 1'b1;
				cmd.src  = SRC_BS;
				state_d  = ST_IDLE;
			end
			ST_LF: begin
				// clearing the walk counter starts the read of entry zero
				cmd.emit     = 1'b1;
				cmd.src      = SRC_LF;
				cmd.walk_clr = 1'b1;
				state_d      = stat.fill_nz ? ST_LINE : ST_END;
			end
			ST_LINE: begin
				cmd.emit     = 1'b1;
				cmd.src      = SRC_LINE;
				cmd.walk_inc = 1'b1;
				if (stat.walk_last) begin
					state_d = ST_END;
				end
			end
			ST_END: begin
				cmd.emit     = 1'b1;
				cmd.last     = 1'b1;
				cmd.src      = SRC_END;
				cmd.fill_clr = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/sle_dp.sv @@
// Datapath: limit register, fill count, line store, walk counter and result register.
module sle_dp import sle_pkg::*; #(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [LIMIT_W-1:0]  cfg_data,
	input  logic [BYTE_W-1:0]   rx_byte,
	input  sle_cmd_t            cmd,
	output sle_stat_t           stat,
	output logic                strobe,
	output logic [KIND_W-1:0]   out_kind,
	output logic [BYTE_W-1:0]   out_byte,
	output logic [LEN_W-1:0]    line_length,
	output logic                aborted,
	output logic                last
);

	localparam int FW = $clog2(LINE_MAX);
	localparam int CW = LIMIT_W + 1;
	localparam logic [CW-1:0] MAX_L = CW'(LINE_MAX);

	logic [LIMIT_W-1:0] limit_q;
	logic [FW-1:0]      fill_q;
	logic [FW-1:0]      walk_q;
	logic [FW-1:0]      walk_d;
	logic               abort_q;
	logic [BYTE_W-1:0]  store_q [LINE_MAX];
	logic [BYTE_W-1:0]  rd_data_q;
	logic [CW-1:0]      lim_eff;
	logic [CW-1:0]      fill_ext;
	logic [FW+LEN_W-1:0] fill_len;

	logic               strobe_q;
	logic [KIND_W-1:0]  kind_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [LEN_W-1:0]   len_q;
	logic               abort_out_q;
	logic               last_q;

	logic [KIND_W-1:0]  kind_d;
	logic [BYTE_W-1:0]  byte_d;
	logic [LEN_W-1:0]   len_d;
	logic               abort_out_d;

	always_comb begin
		if (limit_q == '0) begin
			lim_eff = CW'(1);
		end else if ({1'b0, limit_q} > MAX_L) begin
			lim_eff = MAX_L;
		end else begin
			lim_eff = {1'b0, limit_q};
		end
		fill_ext = CW'(fill_q);
		fill_len = {{LEN_W{1'b0}}, fill_q};
	end

	assign stat.printable = (rx_byte >= CH_SP) && (rx_byte <= CH_TILDE);
	assign stat.erase     = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
	assign stat.cr        = (rx_byte == CH_CR);
	assign stat.etx       = (rx_byte == CH_ETX);
	assign stat.can_store = (fill_ext + CW'(1)) < lim_eff;
	assign stat.fill_nz   = (fill_q != '0);
	assign stat.walk_last = (walk_q + FW'(1)) == fill_q;

	always_comb begin
		if (cmd.walk_clr) begin
			walk_d = '0;
		end else if (cmd.walk_inc) begin
			walk_d = walk_q + FW'(1);
		end else begin
			walk_d = walk_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RST;
			fill_q   <= '0;
			walk_q   <= '0;
			abort_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.fill_clr) begin
				fill_q <= '0;
			end else if (cmd.fill_inc) begin
				fill_q <= fill_q + FW'(1);
			end else if (cmd.fill_dec) begin
				fill_q <= fill_q - FW'(1);
			end
			if (cmd.abort_ld) begin
				abort_q <= stat.etx;
			end
			walk_q   <= walk_d;
			strobe_q <= cmd.emit;
		end
	end

	// line store: one write port, one registered read at the next walk index
	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			store_q[fill_q] <= rx_byte;
		end
		rd_data_q <= store_q[walk_d];
	end

	always_comb begin
		kind_d      = KIND_ECHO;
		byte_d      = '0;
		len_d       = '0;
		abort_out_d = 1'b0;
		case (cmd.src)
			SRC_RX:   byte_d = rx_byte;
			SRC_BS:   byte_d = CH_BS;
			SRC_SP:   byte_d = CH_SP;
			SRC_CR:   byte_d = CH_CR;
			SRC_LF:   byte_d = CH_LF;
			SRC_LINE: begin
				kind_d = KIND_LINE;
				byte_d = rd_data_q;
			end
			SRC_END: begin
				kind_d      = KIND_END;
				byte_d      = '0;
				len_d       = fill_len[LEN_W-1:0];
				abort_out_d = abort_q;
			end
			default:  byte_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q      <= cmd.last;
			kind_q      <= kind_d;
			byte_q      <= byte_d;
			len_q       <= len_d;
			abort_out_q <= abort_out_d;
		end
	end

	assign strobe      = strobe_q;
	assign out_kind    = kind_q;
	assign out_byte    = byte_q;
	assign line_length = len_q;
	assign aborted     = abort_out_q;
	assign last        = last_q;

endmodule

@@ rtl/core/serial_line_editor_unit.sv @@
// Top level of the serial line editor: sequencer plus datapath.
//
//  channel  | handshake            | words
//  ---------+----------------------+--------------------------------------------
//  input    | start / busy         | rx_byte
//  result   | strobe (no backpress)| out_kind, out_byte, line_length, aborted,
//           |                      | last
//  config   | cfg_valid / cfg_ready| cfg_data (line_limit)
//
// A kept printable byte is echoed in the next cycle; busy stays low so bytes
// may arrive back to back. Backspace echoes BS, SP, BS; ctrl-C CR, LF and an end
// marker; CR gives CR, LF, a line word per kept byte (one store read each, via
// the single read port of the line store) and an end marker. Asynchronous reset
// returns to idle, empty line, limit 32; store not cleared. Results cannot stall.
module serial_line_editor_unit import sle_pkg::*; #(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [BYTE_W-1:0]  rx_byte,
	output logic               strobe,
	output logic [KIND_W-1:0]  out_kind,
	output logic [BYTE_W-1:0]  out_byte,
	output logic [LEN_W-1:0]   line_length,
	output logic               aborted,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data
);

	sle_cmd_t  cmd;
	sle_stat_t stat;

	assign cfg_ready = ~busy;

	sle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	sle_dp #(
		.LINE_MAX (LINE_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_data    (cfg_data),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.stat        (stat),
		.strobe      (strobe),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.line_length (line_length),
		.aborted     (aborted),
		.last        (last)
	);

endmodule

@@ rtl/core/sle_checker.sv @@
// Port-level assertions for the serial line editor, bound to the top level.
module sle_checker import sle_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [BYTE_W-1:0]  rx_byte,
	input logic               strobe,
	input logic [KIND_W-1:0]  out_kind,
	input logic [BYTE_W-1:0]  out_byte,
	input logic [LEN_W-1:0]   line_length,
	input logic               aborted,
	input logic               last
);

	// an aborted line always reports zero length
	a_abort_len: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && out_kind == KIND_END && aborted) |-> (line_length == '0))
		else $error("aborted end marker with nonzero length");

	// line words are always followed by more of the sequence
	a_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && out_kind == KIND_LINE) |-> busy)
		else $error("line word seen while idle");

	// ctrl-C is echoed with CR first
	a_etx_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && rx_byte == CH_ETX) |=>
		(strobe && out_kind == KIND_ECHO && out_byte == CH_CR && !last))
		else $error("ctrl-C not echoed with CR");

	// a word that is not the final one leaves the block busy
	a_notlast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("sequence cut short");

	// leaving busy coincides with the final word of the sequence
	a_fell_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last))
		else $error("busy dropped without final word");

endmodule

bind serial_line_editor_unit sle_checker u_sle_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.rx_byte     (rx_byte),
	.strobe      (strobe),
	.out_kind    (out_kind),
	.out_byte    (out_byte),
	.line_length (line_length),
	.aborted     (aborted),
	.last        (last)
);

@@ dv/serial_line_editor_unit_tb.sv @@
// Self-checking testbench for the serial line editor: directed keys, limit settings, random lines.
module serial_line_editor_unit_tb;
	import sle_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
		logic              ab;
		logic              fin;
	} out_word_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [BYTE_W-1:0]  rx_byte = '0;
	logic               strobe;
	logic [KIND_W-1:0]  out_kind;
	logic [BYTE_W-1:0]  out_byte;
	logic [LEN_W-1:0]   line_length;
	logic               aborted;
	logic               last;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data = '0;

	// predictor state
	logic [BYTE_W-1:0]  kept_chars [LINE_MAX_DEF];
	int unsigned        held_count = 0;
	logic [LIMIT_W-1:0] limit_reg = LIMIT_RST;

	out_word_t          due_words [$];
	int                 mismatches = 0;
	int                 idle_pct = 0;
	int                 quiet_cycles = 0;

	serial_line_editor_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.rx_byte     (rx_byte),
		.strobe      (strobe),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.line_length (line_length),
		.aborted     (aborted),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void push_word(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
		logic [LEN_W-1:0] len, logic ab, logic fin);
		out_word_t w;
		w.kind = kind;
		w.data = data;
		w.len  = len;
		w.ab   = ab;
		w.fin  = fin;
		due_words.push_back(w);
	endfunction

	// expected words for one accepted key, updates the held line
	function automatic void apply_keystroke(logic [BYTE_W-1:0] x);
		int unsigned eff;
		eff = 32'(limit_reg);
		if (eff < 1)
			eff = 1;
		if (eff > LINE_MAX_DEF)
			eff = LINE_MAX_DEF;
		if (x >= CH_SP && x <= CH_TILDE) begin
			if (held_count < eff - 1) begin
				kept_chars[held_count] = x;
				held_count++;
				push_word(KIND_ECHO, x, '0, 1'b0, 1'b1);
			end
		end else if (x == CH_BS || x == CH_DEL) begin
			if (held_count != 0) begin
				push_word(KIND_ECHO, CH_BS, '0, 1'b0, 1'b0);
				push_word(KIND_ECHO, CH_SP, '0, 1'b0, 1'b0);
				push_word(KIND_ECHO, CH_BS, '0, 1'b0, 1'b1);
				held_count--;
			end
		end else if (x == CH_CR) begin
			push_word(KIND_ECHO, CH_CR, '0, 1'b0, 1'b0);
			push_word(KIND_ECHO, CH_LF, '0, 1'b0, 1'b0);
			for (int unsigned i = 0; i < held_count; i++)
				push_word(KIND_LINE, kept_chars[i], '0, 1'b0, 1'b0);
			push_word(KIND_END, '0, LEN_W'(held_count), 1'b0, 1'b1);
			held_count = 0;
		end else if (x == CH_ETX) begin
			push_word(KIND_ECHO, CH_CR, '0, 1'b0, 1'b0);
			push_word(KIND_ECHO, CH_LF, '0, 1'b0, 1'b0);
			push_word(KIND_END, '0, '0, 1'b1, 1'b1);
			held_count = 0;
		end
	endfunction

	task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_word_t w;
		if (arst_n && strobe) begin
			if (due_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got kind %0h byte %0h", $time,
					out_kind, out_byte);
				mismatches++;
			end else begin
				w = due_words.pop_front();
				check_field("out_kind", 8'(w.kind), 8'(out_kind));
				check_field("out_byte", w.data, out_byte);
				check_field("line_length", 8'(w.len), 8'(line_length));
				check_field("aborted", 8'(w.ab), 8'(aborted));
				check_field("last", 8'(w.fin), 8'(last));
			end
		end
	end

	// watchdog: cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("serial_line_editor_unit_tb NOT OK");
			$finish;
		end
	end

	// called at a rising edge, returns at the edge that accepted the key
	task automatic send_key(logic [BYTE_W-1:0] x);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		rx_byte <= x;
		do @(posedge clk); while (busy);
		apply_keystroke(x);
	endtask

	task automatic drain_words();
		start <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		// dropped or ignored keys give no word but may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] v);
		drain_words();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		limit_reg = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] rand_printable();
		return BYTE_W'($urandom_range(CH_SP, CH_TILDE));
	endfunction

	function automatic logic [BYTE_W-1:0] rand_noise();
		logic [BYTE_W-1:0] x;
		do begin
			if ($urandom_range(1))
				x = BYTE_W'($urandom_range(8'h80, 8'hFF));
			else
				x = BYTE_W'($urandom_range(8'h00, 8'h1F));
		end while (x == CH_ETX || x == CH_BS || x == CH_CR);
		return x;
	endfunction

	task automatic test_plain_keys();
		send_key(8'h00);
		send_key(8'hFF);
		send_key(8'h1F);
		send_key(8'h80);
		send_key(CH_BS);
		send_key(CH_DEL);
		send_key(CH_SP);
		send_key(CH_TILDE);
		send_key(8'h41);
		send_key(CH_DEL);
		send_key(CH_BS);
		send_key(8'h7A);
		send_key(CH_CR);
		send_key(8'h71);
		send_key(CH_ETX);
		send_key(CH_ETX);
		send_key(CH_CR);
	endtask

	task automatic test_limit_edges();
		write_limit(6'd1);
		send_key(8'h61);
		send_key(CH_CR);
		write_limit(6'd0);
		send_key(8'h62);
		send_key(CH_CR);
		write_limit(6'd2);
		send_key(8'h63);
		send_key(8'h64);
		send_key(CH_CR);
		write_limit(6'd63);
		send_key(8'h65);
		send_key(8'h66);
		send_key(CH_CR);
	endtask

	task automatic test_limit_lowered();
		write_limit(6'd32);
		repeat (5) send_key(rand_printable());
		write_limit(6'd3);
		send_key(8'h78);
		repeat (3) send_key(CH_BS);
		send_key(8'h79);
		send_key(CH_DEL);
		send_key(8'h7A);
		send_key(CH_CR);
	endtask

	task automatic test_full_line();
		write_limit(6'd32);
		repeat (LINE_MAX_DEF + 1) send_key(rand_printable());
		send_key(CH_CR);
	endtask

	// mostly well-formed lines with random content, some edits and noise
	task automatic test_random_lines(int pct, logic [LIMIT_W-1:0] lim, int n_keys);
		int sent;
		int len;
		write_limit(lim);
		idle_pct = pct;
		sent = 0;
		while (sent < n_keys) begin
			if ($urandom_range(7) == 0)
				len = $urandom_range(0, LINE_MAX_DEF + 2);
			else
				len = $urandom_range(0, 12);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(19))
					0, 1: begin
						send_key($urandom_range(1) ? CH_BS : CH_DEL);
						sent++;
					end
					2: send_key(rand_noise());
					default: begin
						send_key(rand_printable());
						sent++;
					end
				endcase
			end
			send_key($urandom_range(6) == 0 ? CH_ETX : CH_CR);
			sent++;
		end
		idle_pct = 0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_keys();
		test_limit_edges();
		test_limit_lowered();
		test_full_line();
		test_random_lines(0, 6'd32, 18);
		test_random_lines(80, 6'd6, 18);
		test_random_lines(16, 6'd17, 14);
		drain_words();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && due_words.size() == 0)
			$display("serial_line_editor_unit_tb OK");
		else
			$display("serial_line_editor_unit_tb NOT OK");
		$finish;
	end

endmodule
